>>> design/fuzzy_gain_inference_defines.svh
// Assertion macros shared by the fuzzy gain inference design.
`ifndef FUZZY_GAIN_INFERENCE_DEFINES_SVH
`define FUZZY_GAIN_INFERENCE_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define FGI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define FGI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fgi_pkg.sv
// Types, constants and rule tables of the fuzzy gain inference pipeline.
package fgi_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int RANGE_W = 15;
  localparam int LIM_W = 31;
  localparam int DIV_STEPS = 16;
  localparam int OUT_W = 14;
  localparam int LVL_MAX = 49152;
  localparam int LIM_MULT = LVL_MAX + 1;
  localparam int ERR_RANGE_RST = 3840;
  localparam int RATE_RANGE_RST = 768;
  localparam int SEG_SPAN = 16384;
  localparam int OUT_MAX = 4096;
  localparam int ROUND_HALF = 196608;
  localparam int RECIP6 = 10923;

  typedef enum logic [1:0] {
    CFG_ERROR_RANGE = 2'd0,
    CFG_RATE_RANGE  = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [15:0] rem;
    logic [15:0] low;
    logic [15:0] quo;
  } lane_t;

  localparam logic signed [3:0] PROP_TAB [0:6][0:6] = '{
    '{ 4'sd6,  4'sd6,  4'sd6,  4'sd6,  4'sd6,  4'sd4,  4'sd6},
    '{-4'sd4, -4'sd2, -4'sd2,  4'sd6,  4'sd4,  4'sd4,  4'sd6},
    '{ 4'sd6,  4'sd4,  4'sd6,  4'sd2,  4'sd2,  4'sd6,  4'sd6},
    '{ 4'sd4,  4'sd4,  4'sd2,  4'sd6,  4'sd6, -4'sd2, -4'sd2},
    '{ 4'sd6,  4'sd6,  4'sd2,  4'sd6,  4'sd6,  4'sd4,  4'sd6},
    '{ 4'sd6,  4'sd4,  4'sd4,  4'sd6, -4'sd2, -4'sd2, -4'sd4},
    '{ 4'sd6,  4'sd4,  4'sd6,  4'sd6,  4'sd6,  4'sd6,  4'sd6}
  };

  localparam logic signed [3:0] DERIV_TAB [0:6][0:6] = '{
    '{ 4'sd6,  4'sd4,  4'sd2, -4'sd2,  4'sd0, -4'sd2, -4'sd2},
    '{ 4'sd6,  4'sd4,  4'sd2,  4'sd0, -4'sd2, -4'sd4, -4'sd6},
    '{ 4'sd6,  4'sd4,  4'sd2,  4'sd0,  4'sd0, -4'sd2,  4'sd2},
    '{ 4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd3,  4'sd2},
    '{ 4'sd2, -4'sd2,  4'sd0,  4'sd0,  4'sd2,  4'sd4,  4'sd6},
    '{-4'sd6, -4'sd4, -4'sd2,  4'sd0,  4'sd2,  4'sd4,  4'sd6},
    '{-4'sd2, -4'sd2,  4'sd0, -4'sd2,  4'sd2,  4'sd4,  4'sd6}
  };

  function automatic logic signed [3:0] rule(input logic fsel, input logic [2:0] row,
                                             input logic [2:0] col);
    logic signed [3:0] v;
    v = fsel ? DERIV_TAB[row][col] : PROP_TAB[row][col];
    return v;
  endfunction

  function automatic lane_t div_step(input lane_t a, input logic [RANGE_W-1:0] r,
                                     input logic [3:0] bpos);
    lane_t       o;
    logic [16:0] trial;
    o = a;
    trial = {a.rem, a.low[bpos]};
    if (trial >= {2'b00, r}) begin
      o.rem = 16'(trial - {2'b00, r});
      o.quo[bpos] = 1'b1;
    end else begin
      o.rem = trial[15:0];
    end
    return o;
  endfunction

  // Splits a quotient into the lower fuzzy set and the upper membership.
  function automatic logic [17:0] fuzzify(input lane_t a);
    logic [15:0] qv;
    logic [16:0] u;
    logic [2:0]  seg;
    logic [14:0] upper;
    qv = a.sat ? 16'(LVL_MAX) : a.quo;
    u = a.neg ? 17'(LVL_MAX) - {1'b0, qv} : 17'(LVL_MAX) + {1'b0, qv};
    if (u[16:14] > 3'd5) begin
      seg = 3'd5;
      upper = 15'(SEG_SPAN);
    end else begin
      seg = u[16:14];
      upper = {1'b0, u[13:0]};
    end
    return {seg, upper};
  endfunction

endpackage

>>> design/fuzzy_gain_inference.sv
// Top level of the fuzzy gain inference pipeline.
//
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_func, in_error, in_error_rate
// out     | output    | out_valid / out_ready  | out_gain_adjust
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
//
// One word enters per cycle unless the output stalls; the 16 restoring
// divider steps scale each input by its range register.
// All stages advance together whenever the output register is free or taken.
// A stall freezes every stage, so nothing is lost or repeated.
// Reset clears the valid bits and loads the default range registers.
`include "fuzzy_gain_inference_defines.svh"

module fuzzy_gain_inference
  import fgi_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic signed [VALUE_WIDTH-1:0] in_error,
  input  logic signed [VALUE_WIDTH-1:0] in_error_rate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       out_gain_adjust,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  localparam int CW = (VALUE_WIDTH + 16 > 32) ? VALUE_WIDTH + 16 : 32;

  logic [RANGE_W-1:0] err_range_r, rate_range_r;
  logic [LIM_W-1:0]   err_lim_r, rate_lim_r;
  logic [RANGE_W-1:0] wr_range;
  logic [LIM_W-1:0]   wr_lim;

  logic adv;

  // Front stages.
  logic              v1_r, f1_r, en1_r, rn1_r;
  logic [CW-1:0]     en_r, rn_r;
  logic [VALUE_WIDTH-1:0] e_mag, r_mag;
  logic [CW-1:0]     e_n_nxt, r_n_nxt;

  // Divider stages.
  logic  dv_r [0:DIV_STEPS];
  logic  df_r [0:DIV_STEPS];
  lane_t de_r [0:DIV_STEPS];
  lane_t dr_r [0:DIV_STEPS];
  lane_t de_nxt [0:DIV_STEPS];
  lane_t dr_nxt [0:DIV_STEPS];

  // Back stages.
  logic [17:0]       ef, rf;
  logic              p1v_r, p2v_r, p3v_r, p4v_r, p5v_r, out_v_r;
  logic signed [3:0] c00_r, c01_r, c10_r, c11_r;
  logic signed [3:0] c00b_r, c01b_r, c10b_r, c11b_r;
  logic [14:0]       eu_r, el_r, ru_r, rl_r;
  logic [28:0]       w00_r, w01_r, w10_r, w11_r;
  logic signed [32:0] t00_r, t01_r, t10_r, t11_r;
  logic signed [31:0] sum_r;
  logic signed [34:0] sum_nxt;
  logic [31:0]       s_abs;
  logic [31:0]       t_rnd;
  logic              neg5_r, neg4_nxt;
  logic [15:0]       v5_r;
  logic [31:0]       qd_full;
  logic [12:0]       qd;
  logic [OUT_W-1:0]  q_mag;
  logic signed [OUT_W-1:0] gain_r;

  assign adv = !out_v_r || out_ready;
  assign in_ready = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_gain_adjust = gain_r;

  assign wr_range = (cfg_wdata[14:0] == '0) ? RANGE_W'(1) : cfg_wdata[14:0];
  assign wr_lim = LIM_W'({16'd0, wr_range} * LIM_W'(LIM_MULT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_range_r <= RANGE_W'(ERR_RANGE_RST);
      rate_range_r <= RANGE_W'(RATE_RANGE_RST);
      err_lim_r <= LIM_W'(ERR_RANGE_RST * LIM_MULT);
      rate_lim_r <= LIM_W'(RATE_RANGE_RST * LIM_MULT);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ERROR_RANGE: begin
          err_range_r <= wr_range;
          err_lim_r <= wr_lim;
        end
        CFG_RATE_RANGE: begin
          rate_range_r <= wr_range;
          rate_lim_r <= wr_lim;
        end
        default: ;
      endcase
    end
  end

  assign e_mag = in_error[VALUE_WIDTH-1] ? VALUE_WIDTH'(-in_error) : in_error;
  assign r_mag = in_error_rate[VALUE_WIDTH-1] ? VALUE_WIDTH'(-in_error_rate) : in_error_rate;
  assign e_n_nxt = ((CW'(e_mag) << 1) + CW'(e_mag)) << 14;
  assign r_n_nxt = ((CW'(r_mag) << 1) + CW'(r_mag)) << 14;

  always_comb begin
    de_nxt[0] = '0;
    dr_nxt[0] = '0;
    de_nxt[0].neg = en1_r;
    dr_nxt[0].neg = rn1_r;
    de_nxt[0].sat = en_r >= CW'(err_lim_r);
    dr_nxt[0].sat = rn_r >= CW'(rate_lim_r);
    de_nxt[0].rem = en_r[31:16];
    dr_nxt[0].rem = rn_r[31:16];
    de_nxt[0].low = en_r[15:0];
    dr_nxt[0].low = rn_r[15:0];
    for (int k = 0; k < DIV_STEPS; k++) begin
      de_nxt[k+1] = div_step(de_r[k], err_range_r, 4'(DIV_STEPS - 1 - k));
      dr_nxt[k+1] = div_step(dr_r[k], rate_range_r, 4'(DIV_STEPS - 1 - k));
    end
  end

  assign ef = fuzzify(de_r[DIV_STEPS]);
  assign rf = fuzzify(dr_r[DIV_STEPS]);

  assign sum_nxt = 35'(t00_r) + 35'(t01_r) + 35'(t10_r) + 35'(t11_r);
  assign neg4_nxt = sum_r[31];
  assign s_abs = sum_r[31] ? 32'(-sum_r) : 32'(sum_r);
  assign t_rnd = s_abs + 32'(ROUND_HALF);
  assign qd_full = ({16'd0, v5_r} * 32'(RECIP6)) >> 16;
  assign qd = (qd_full > 32'(OUT_MAX)) ? 13'(OUT_MAX) : qd_full[12:0];
  assign q_mag = OUT_W'(qd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_r[k] <= 1'b0;
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
      p3v_r <= 1'b0;
      p4v_r <= 1'b0;
      p5v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      dv_r[0] <= v1_r;
      for (int k = 0; k < DIV_STEPS; k++) dv_r[k+1] <= dv_r[k];
      p1v_r <= dv_r[DIV_STEPS];
      p2v_r <= p1v_r;
      p3v_r <= p2v_r;
      p4v_r <= p3v_r;
      p5v_r <= p4v_r;
      out_v_r <= p5v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r <= in_func;
      en1_r <= in_error[VALUE_WIDTH-1];
      rn1_r <= in_error_rate[VALUE_WIDTH-1];
      en_r <= e_n_nxt;
      rn_r <= r_n_nxt;
      df_r[0] <= f1_r;
      for (int k = 0; k < DIV_STEPS; k++) df_r[k+1] <= df_r[k];
      for (int k = 0; k <= DIV_STEPS; k++) begin
        de_r[k] <= de_nxt[k];
        dr_r[k] <= dr_nxt[k];
      end
      c00_r <= rule(df_r[DIV_STEPS], ef[17:15], rf[17:15]);
      c01_r <= rule(df_r[DIV_STEPS], ef[17:15], rf[17:15] + 3'd1);
      c10_r <= rule(df_r[DIV_STEPS], ef[17:15] + 3'd1, rf[17:15]);
      c11_r <= rule(df_r[DIV_STEPS], ef[17:15] + 3'd1, rf[17:15] + 3'd1);
      eu_r <= ef[14:0];
      el_r <= 15'(SEG_SPAN) - ef[14:0];
      ru_r <= rf[14:0];
      rl_r <= 15'(SEG_SPAN) - rf[14:0];
      w00_r <= 29'({15'd0, el_r} * {15'd0, rl_r});
      w01_r <= 29'({15'd0, el_r} * {15'd0, ru_r});
      w10_r <= 29'({15'd0, eu_r} * {15'd0, rl_r});
      w11_r <= 29'({15'd0, eu_r} * {15'd0, ru_r});
      c00b_r <= c00_r;
      c01b_r <= c01_r;
      c10b_r <= c10_r;
      c11b_r <= c11_r;
      t00_r <= 33'(c00b_r) * $signed({4'd0, w00_r});
      t01_r <= 33'(c01b_r) * $signed({4'd0, w01_r});
      t10_r <= 33'(c10b_r) * $signed({4'd0, w10_r});
      t11_r <= 33'(c11b_r) * $signed({4'd0, w11_r});
      sum_r <= 32'(sum_nxt);
      neg5_r <= neg4_nxt;
      v5_r <= t_rnd[31:16];
      gain_r <= neg5_r ? OUT_W'(-q_mag) : q_mag;
    end
  end

  `FGI_ASSERT_SAME(a_out_span, out_v_r,
    (gain_r <= OUT_W'(OUT_MAX)) && (gain_r >= -OUT_W'(OUT_MAX)),
    "gain adjustment outside of [-1,1]")
  `FGI_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v1_r,
    "accepted word did not enter the first stage")
  `FGI_ASSERT_NEXT(a_stall_holds, !adv, $stable(dv_r[DIV_STEPS]) && $stable(p3v_r),
    "pipeline moved during a stall")
  `FGI_ASSERT_SAME(a_div_start, dv_r[0] && !de_r[0].sat,
    {1'b0, de_r[0].rem} < {2'b00, err_range_r},
    "divider partial remainder not below the range")

endmodule

>>> tb/sv/fgi_checker.sv
// Checker that predicts every gain adjustment and compares it with the block's output.
module fgi_checker
  import fgi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  logic signed [15:0] in_error,
  input  logic signed [15:0] in_error_rate,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [13:0] out_gain_adjust,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int P_RULES [7][7] = '{
    '{ 6,  6,  6,  6,  6,  4,  6},
    '{-4, -2, -2,  6,  4,  4,  6},
    '{ 6,  4,  6,  2,  2,  6,  6},
    '{ 4,  4,  2,  6,  6, -2, -2},
    '{ 6,  6,  2,  6,  6,  4,  6},
    '{ 6,  4,  4,  6, -2, -2, -4},
    '{ 6,  4,  6,  6,  6,  6,  6}
  };
  localparam int D_RULES [7][7] = '{
    '{ 6,  4,  2, -2,  0, -2, -2},
    '{ 6,  4,  2,  0, -2, -4, -6},
    '{ 6,  4,  2,  0,  0, -2,  2},
    '{ 2, -2, -2, -2, -2, -3,  2},
    '{ 2, -2,  0,  0,  2,  4,  6},
    '{-6, -4, -2,  0,  2,  4,  6},
    '{-2, -2,  0, -2,  2,  4,  6}
  };

  logic [14:0]        error_span;
  logic [14:0]        rate_span;
  logic signed [13:0] gain_queue [$];

  function automatic void split_level(input longint x, input logic [14:0] span,
                                      output int seg, output longint upper);
    longint r;
    longint lvl;
    longint u;
    r = (span == 0) ? 1 : longint'(span);
    lvl = (x * 49152) / r;
    if (lvl > 49152) lvl = 49152;
    if (lvl < -49152) lvl = -49152;
    u = lvl + 49152;
    seg = int'(u / 16384);
    if (seg > 5) seg = 5;
    upper = u - longint'(seg) * 16384;
  endfunction

  function automatic int rule_at(input logic f, input int row, input int col);
    return f ? D_RULES[row][col] : P_RULES[row][col];
  endfunction

  function automatic logic signed [13:0] predict_gain(input logic f,
      input logic signed [15:0] e, input logic signed [15:0] r,
      input logic [14:0] espan, input logic [14:0] rspan);
    int     es;
    int     rs;
    longint eu;
    longint ru;
    longint el;
    longint rl;
    longint sum;
    longint mag;
    longint q;
    split_level(longint'(e), espan, es, eu);
    split_level(longint'(r), rspan, rs, ru);
    el = 16384 - eu;
    rl = 16384 - ru;
    sum = rule_at(f, es, rs) * el * rl + rule_at(f, es, rs + 1) * el * ru
        + rule_at(f, es + 1, rs) * eu * rl + rule_at(f, es + 1, rs + 1) * eu * ru;
    mag = (sum < 0) ? -sum : sum;
    q = mag / 393216;
    if (2 * (mag - q * 393216) >= 393216) q++;
    if (sum < 0) q = -q;
    if (q > 4096) q = 4096;
    if (q < -4096) q = -4096;
    return 14'(q);
  endfunction

  assign pending = gain_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      error_span <= 15'(ERR_RANGE_RST);
      rate_span <= 15'(RATE_RANGE_RST);
      fail_count <= 0;
      gain_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ERROR_RANGE) error_span <= cfg_wdata[14:0];
        else if (cfg_index == CFG_RATE_RANGE) rate_span <= cfg_wdata[14:0];
      end
      if (in_valid && in_ready) begin
        gain_queue.push_back(predict_gain(in_func, in_error, in_error_rate,
                                          error_span, rate_span));
      end
      if (out_valid && out_ready) begin
        if (gain_queue.size() == 0) begin
          $error("gain_adjust: unexpected word, actual %0d", out_gain_adjust);
          fail_count <= fail_count + 1;
        end else if (gain_queue[0] !== out_gain_adjust) begin
          $error("gain_adjust: expected %0d, actual %0d", gain_queue[0], out_gain_adjust);
          fail_count <= fail_count + 1;
          void'(gain_queue.pop_front());
        end else begin
          void'(gain_queue.pop_front());
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_fuzzy_gain_inference.sv
// Stimulus and verdict for the fuzzy gain inference pipeline.
module tb_fuzzy_gain_inference;
  import fgi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int STALL_LIMIT = 5000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_func;
  logic signed [15:0] in_error;
  logic signed [15:0] in_error_rate;
  logic               out_valid;
  logic               out_ready;
  logic signed [13:0] out_gain_adjust;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 quiet_cycles;
  bit                 no_idle;
  bit                 hold_output;
  logic [14:0]        espan;
  logic [14:0]        rspan;

  fuzzy_gain_inference u_top (.*);

  fgi_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("fuzzy_gain_inference verification failed");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send_word(input logic f, input logic signed [15:0] e,
                           input logic signed [15:0] r);
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_error <= e;
    in_error_rate <= r;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ERROR_RANGE) espan = data[14:0];
    else if (idx == CFG_RATE_RANGE) rspan = data[14:0];
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] near_span(input logic [14:0] span);
    int s;
    int v;
    s = (span == 0) ? 1 : int'(span);
    case ($urandom_range(9))
      0: v = $urandom;
      1: v = s;
      2: v = -s;
      default: v = $urandom_range(2 * s + s / 4 + 2) - s - s / 8 - 1;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic random_words(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        send_word(1'($urandom), 16'($urandom), 16'($urandom));
      else
        send_word(1'($urandom), near_span(espan), near_span(rspan));
    end
  endtask

  task automatic directed_words();
    logic signed [15:0] vals [8];
    vals = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd3840, -16'sd3840, 16'sd768,
             -16'sd768, 16'sd1};
    for (int i = 0; i < 8; i++) begin
      send_word(1'b0, vals[i], vals[7 - i]);
      send_word(1'b1, vals[i], vals[(i + 3) % 8]);
    end
    send_word(1'b1, 16'sd1920, 16'sd384);
    send_word(1'b0, 16'sd5000, -16'sd2000);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_error = '0;
    in_error_rate = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ERROR_RANGE;
    cfg_wdata = '0;
    no_idle = 1'b0;
    hold_output = 1'b0;
    espan = 15'(ERR_RANGE_RST);
    rspan = 15'(RATE_RANGE_RST);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();
    random_words(250);
    hold_output = 1'b1;
    random_words(150);
    drain();

    write_reg(CFG_ERROR_RANGE, 16'd1);
    write_reg(CFG_RATE_RANGE, 16'd1);
    send_word(1'b0, 16'sd1, -16'sd1);
    send_word(1'b1, 16'sh7FFF, 16'sh8000);
    random_words(200);
    drain();

    write_reg(CFG_ERROR_RANGE, 16'h7FFF);
    write_reg(CFG_RATE_RANGE, 16'hFFFF);
    send_word(1'b0, 16'sh7FFF, 16'sh8000);
    send_word(1'b1, 16'sh8001, 16'sh7FFF);
    no_idle = 1'b1;
    random_words(300);
    no_idle = 1'b0;
    drain();

    write_reg(CFG_ERROR_RANGE, 16'h8000);
    write_reg(CFG_RATE_RANGE, 16'd0);
    write_reg(CFG_SPARE_A, 16'h1234);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    send_word(1'b0, 16'sd0, 16'sd0);
    send_word(1'b1, -16'sd1, 16'sd1);
    random_words(150);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_ERROR_RANGE, 16'($urandom));
      write_reg(CFG_RATE_RANGE, 16'($urandom_range(2000, 1)));
      random_words(200);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("fuzzy_gain_inference verification clean");
    end else begin
      $display("fuzzy_gain_inference verification failed");
    end
    $finish;
  end
endmodule
